[rtl/core/ctt_pkg.sv]
// Types, constants and per-byte lexing functions for the configuration text tokenizer.
package ctt_pkg;

    localparam int MAX_RES = 3;

    // Token type codes as they appear on the result channel.
    typedef enum logic [2:0] {
        TY_NONE  = 3'd0,
        TY_NUM   = 3'd1,
        TY_LABEL = 3'd2,
        TY_STR   = 3'd3,
        TY_SYM   = 3'd4
    } tok_type_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // One result item.
    typedef struct packed {
        logic [7:0]  ch;
        logic        valid;
        tok_type_t   typ;
        logic        last;
        logic [31:0] value;
        logic        ok;
        logic [15:0] line;
        logic        err;
    } res_t;

    // Lexer state plus the results collected during one step.
    typedef struct packed {
        tok_type_t   typ;
        logic [8:0]  cnt;
        logic [7:0]  hchar;
        logic        hvalid;
        logic [8:0]  psign;
        logic        pcr;
        logic        skip;
        logic [15:0] line;
        logic [31:0] acc;
        logic        f_neg;
        logic        f_sign;
        logic        f_hex;
        logic        f_bad;
        logic        err;
        res_t [MAX_RES-1:0] res;
        logic [1:0]  rn;
    } lex_st_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_hexl(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    function automatic logic in_num_set(input logic [7:0] c);
        return is_digit(c) || (c == 8'h2E) || (c == 8'h78) || (c == 8'h58) || is_hexl(c);
    endfunction

    function automatic logic in_label_set(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == 8'h5F);
    endfunction

    function automatic logic in_sym_set(input logic [7:0] c);
        logic r;
        r = 1'b0;
        unique case (c)
            "~", "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "-", "=", "_", "+",
            "{", "}", "[", "]", "|", "\\", ":", ";", "'", "<", ">", "?", ",", ".",
            "/": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Append one result item, using the current line count and error flag.
    function automatic lex_st_t f_emit(input lex_st_t st, input logic [7:0] ch,
                                       input logic valid, input tok_type_t typ,
                                       input logic last, input logic [31:0] value,
                                       input logic ok);
        lex_st_t s;
        s = st;
        if (s.rn < 2'(MAX_RES)) begin
            s.res[s.rn].ch    = ch;
            s.res[s.rn].valid = valid;
            s.res[s.rn].typ   = typ;
            s.res[s.rn].last  = last;
            s.res[s.rn].value = value;
            s.res[s.rn].ok    = ok;
            s.res[s.rn].line  = s.line;
            s.res[s.rn].err   = s.err;
            s.rn = s.rn + 2'd1;
        end
        return s;
    endfunction

    // Number conversion of one accepted character at position pos.
    function automatic lex_st_t f_convert(input lex_st_t st, input logic [7:0] c,
                                          input logic [8:0] pos);
        lex_st_t s;
        logic [8:0] dpos;
        logic [3:0] d;
        logic       dig_ok;
        s = st;
        d = 4'd0;
        dig_ok = 1'b1;
        dpos = pos - {8'd0, s.f_sign};
        if (!s.f_bad) begin
            if ((pos == 9'd0) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
                s.f_sign = 1'b1;
                if (c == CH_MINUS) begin
                    s.f_neg = 1'b1;
                end
            end else if ((dpos == 9'd1) && !s.f_hex && (s.acc == 32'd0) &&
                         ((c == 8'h78) || (c == 8'h58))) begin
                s.f_hex = 1'b1;
            end else begin
                if (is_digit(c)) begin
                    d = 4'(c - 8'h30);
                end else if ((c >= 8'h41) && (c <= 8'h46)) begin
                    d = 4'(c - 8'h37);
                end else if ((c >= 8'h61) && (c <= 8'h66)) begin
                    d = 4'(c - 8'h57);
                end else begin
                    dig_ok = 1'b0;
                end
                if (!dig_ok) begin
                    s.f_bad = 1'b1;
                end else if (s.f_hex) begin
                    s.acc = {s.acc[27:0], 4'd0} + {28'd0, d};
                end else begin
                    // Times ten as two shifted copies.
                    s.acc = {s.acc[28:0], 3'd0} + {s.acc[30:0], 1'b0} + {28'd0, d};
                end
            end
        end
        return s;
    endfunction

    function automatic lex_st_t f_accept(input lex_st_t st, input logic [7:0] c,
                                         input logic [8:0] maxlen);
        lex_st_t s;
        s = st;
        if (s.cnt < maxlen) begin
            if (s.hvalid) begin
                s = f_emit(s, s.hchar, 1'b1, s.typ, 1'b0, 32'd0, 1'b0);
            end
            if (s.typ == TY_NUM) begin
                s = f_convert(s, c, s.cnt);
            end
            s.hchar  = c;
            s.hvalid = 1'b1;
            s.cnt    = s.cnt + 9'd1;
        end
        return s;
    endfunction

    function automatic lex_st_t f_start(input lex_st_t st, input tok_type_t typ);
        lex_st_t s;
        s = st;
        s.typ    = typ;
        s.cnt    = 9'd0;
        s.hvalid = 1'b0;
        s.hchar  = 8'd0;
        s.acc    = 32'd0;
        s.f_neg  = 1'b0;
        s.f_sign = 1'b0;
        s.f_hex  = 1'b0;
        s.f_bad  = 1'b0;
        return s;
    endfunction

    function automatic lex_st_t f_end(input lex_st_t st);
        lex_st_t s;
        logic [31:0] value;
        logic ok;
        s = st;
        value = 32'd0;
        ok = 1'b0;
        if (s.typ != TY_NONE) begin
            if ((s.typ == TY_NUM) && !s.f_bad) begin
                ok = 1'b1;
                value = s.f_neg ? (32'd0 - s.acc) : s.acc;
            end
            s = f_emit(s, s.hvalid ? s.hchar : 8'd0, s.hvalid, s.typ, 1'b1, value, ok);
            s = f_start(s, TY_NONE);
        end
        return s;
    endfunction

    function automatic lex_st_t f_symbol(input lex_st_t st, input logic [7:0] c,
                                         input logic [8:0] maxlen);
        lex_st_t s;
        s = f_start(st, TY_SYM);
        s = f_accept(s, c, maxlen);
        s = f_end(s);
        return s;
    endfunction

    // Close a pending sign and any open token.
    function automatic lex_st_t f_flush(input lex_st_t st, input logic [8:0] maxlen);
        lex_st_t s;
        logic [7:0] sc;
        s = st;
        sc = s.psign[7:0];
        if (s.psign[8]) begin
            s.psign = 9'd0;
            s = f_symbol(s, sc, maxlen);
        end
        s = f_end(s);
        return s;
    endfunction

    // Lexing rule for one byte inside a line.
    function automatic lex_st_t f_lex(input lex_st_t st, input logic [7:0] b,
                                      input logic [8:0] maxlen);
        lex_st_t s;
        logic [7:0] sc;
        logic done;
        s = st;
        sc = s.psign[7:0];
        done = 1'b0;
        if (b == CH_NUL) begin
            s = f_flush(s, maxlen);
            s.skip = 1'b1;
            done = 1'b1;
        end
        if (!done && s.psign[8]) begin
            s.psign = 9'd0;
            if (is_digit(b)) begin
                s = f_start(s, TY_NUM);
                s = f_accept(s, sc, maxlen);
                s = f_accept(s, b, maxlen);
                done = 1'b1;
            end else begin
                s = f_symbol(s, sc, maxlen);
            end
        end
        // Continue or close the open token.
        if (!done) begin
            if (s.typ == TY_NUM) begin
                if (in_num_set(b)) begin
                    s = f_accept(s, b, maxlen);
                    done = 1'b1;
                end else begin
                    s = f_end(s);
                end
            end else if (s.typ == TY_LABEL) begin
                if (in_label_set(b)) begin
                    s = f_accept(s, b, maxlen);
                    done = 1'b1;
                end else begin
                    s = f_end(s);
                end
            end else if (s.typ == TY_STR) begin
                if (b == CH_QUOTE) begin
                    s = f_end(s);
                end else begin
                    s = f_accept(s, b, maxlen);
                end
                done = 1'b1;
            end else if (s.typ != TY_NONE) begin
                s = f_end(s);
            end
        end
        // Start a new token.
        if (!done && (b > CH_SPACE) && (b < 8'h80)) begin
            if (is_digit(b)) begin
                s = f_start(s, TY_NUM);
                s = f_accept(s, b, maxlen);
            end else if ((b == CH_PLUS) || (b == CH_MINUS)) begin
                s.psign = {1'b1, b};
            end else if (is_alpha(b) || (b == 8'h5F)) begin
                s = f_start(s, TY_LABEL);
                s = f_accept(s, b, maxlen);
            end else if (b == CH_QUOTE) begin
                s = f_start(s, TY_STR);
            end else if (in_sym_set(b)) begin
                s = f_symbol(s, b, maxlen);
            end else begin
                s.err = 1'b1;
            end
        end
        return s;
    endfunction

endpackage

[rtl/core/config_text_tokenizer.sv]
// Top level of the configuration text tokenizer: per-byte lexer and result queue.
//
// The tokenizer takes one text byte per accepted input item and gives up to three
// result items for it. The lexer state is updated in the cycle the byte is
// accepted, and its results go into a four-entry result queue that drives the
// master side one item per cycle while m_tready is high. Input is taken whenever
// the queue holds at most one item, so a stream whose bytes each give at most one
// result runs at one byte per cycle when the result side does not stall; a byte
// that gives n results puts n items on the result channel. Configuration writes are
// always taken. Bytes are split into lines of at most LINE_MAX characters.
module config_text_tokenizer #(
    parameter int LINE_MAX = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items: s_tdata = in_byte[7:0]; s_tlast = end_of_input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    // Result items: m_tdata = tok_char[7:0], char_valid[8], int_value[40:9],
    // int_ok[41], line_number[57:42], lex_error[58], zero fill[63:59].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    // m_tuser = tok_type[2:0]; m_tlast = tok_last.
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    // Configuration: max_token_len.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data
);
    import ctt_pkg::*;

    localparam int COL_W = $clog2(LINE_MAX + 1);
    localparam int QD    = 4;

    logic [8:0]       maxlen_reg;
    lex_st_t          st_reg, st_next;
    logic [COL_W-1:0] col_reg, col_next;
    res_t             q_reg [QD];
    logic [1:0]       wr_reg, rd_reg;
    logic [2:0]       cnt_reg, cnt_next;
    logic             in_fire, out_fire;

    assign cfg_ready = 1'b1;
    assign s_tready  = (cnt_reg <= 3'd1);
    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            maxlen_reg <= 9'd64;
        end else if (cfg_valid) begin
            maxlen_reg <= cfg_data;
        end
    end

    // Line handling and lexing of one item.
    always_comb begin
        lex_st_t s;
        logic    done;
        s = st_reg;
        s.rn = 2'd0;
        col_next = col_reg;
        done = 1'b0;
        if (s_tlast) begin
            s = f_flush(s, maxlen_reg);
            s = f_emit(s, 8'd0, 1'b0, TY_NONE, 1'b1, 32'd0, 1'b0);
            col_next = '0;
            s.skip = 1'b0;
            s.pcr = 1'b0;
        end else begin
            // LF right after CR is swallowed.
            if (s.pcr) begin
                s.pcr = 1'b0;
                if (s_tdata == CH_LF) begin
                    done = 1'b1;
                end
            end
            if (!done) begin
                if ((col_reg == '0) && (s.line != 16'hFFFF)) begin
                    s.line = s.line + 16'd1;
                end
                if ((s_tdata == CH_LF) || (s_tdata == CH_CR)) begin
                    s = f_flush(s, maxlen_reg);
                    col_next = '0;
                    s.skip = 1'b0;
                    s.pcr = (s_tdata == CH_CR);
                end else begin
                    col_next = col_reg + COL_W'(1);
                    if (!s.skip) begin
                        s = f_lex(s, s_tdata, maxlen_reg);
                    end
                    // Full-length line ends right after its last character.
                    if (col_next >= COL_W'(LINE_MAX)) begin
                        s = f_flush(s, maxlen_reg);
                        col_next = '0;
                        s.skip = 1'b0;
                    end
                end
            end
        end
        st_next = s;
    end

    // Lexer state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= '0;
            col_reg <= '0;
        end else if (in_fire) begin
            st_reg  <= st_next;
            col_reg <= col_next;
        end
    end

    // Result queue occupancy.
    always_comb begin
        cnt_next = cnt_reg - {2'd0, out_fire};
        if (in_fire) begin
            cnt_next = cnt_next + {1'b0, st_next.rn};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (out_fire) begin
                rd_reg <= rd_reg + 2'd1;
            end
            if (in_fire) begin
                wr_reg <= wr_reg + st_next.rn;
            end
        end
    end

    // Result queue storage.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            for (int i = 0; i < MAX_RES; i++) begin
                if (2'(i) < st_next.rn) begin
                    q_reg[wr_reg + 2'(i)] <= st_next.res[i];
                end
            end
        end
    end

    // Result channel.
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = {5'd0, q_reg[rd_reg].err, q_reg[rd_reg].line, q_reg[rd_reg].ok,
                       q_reg[rd_reg].value, q_reg[rd_reg].valid, q_reg[rd_reg].ch};
    assign m_tuser  = q_reg[rd_reg].typ;
    assign m_tlast  = q_reg[rd_reg].last;

    // The queue never overflows.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'(QD))
        else $error("result queue overflow");

    // Input is held off only while the queue holds two or more items.
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (cnt_reg >= 3'd2))
        else $error("input stalled with room in the queue");

    // The error flag is sticky until reset.
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.err |=> st_reg.err)
        else $error("error flag cleared");

    // Column stays below the line length.
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg < COL_W'(LINE_MAX))
        else $error("column out of range");

endmodule

[tb/config_text_tokenizer_checker.sv]
// Result checker for the configuration text tokenizer: predicts every result item and compares.
`timescale 1ns / 100ps

module config_text_tokenizer_checker #(
    parameter int LINE_MAX = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    output int          errors,
    output int          pending
);
    import ctt_pkg::*;

    // One predicted token result.
    typedef struct {
        logic [7:0]  ch;
        logic        cvalid;
        tok_type_t   ttype;
        logic        last;
        logic [31:0] value;
        logic        ok;
        logic [15:0] line;
        logic        err;
    } token_res_t;

    token_res_t  expected_tokens[$];
    int          err_count;
    int          step_n;

    // Lexer state of the prediction.
    logic [8:0]  max_len;
    tok_type_t   open_type;
    logic [8:0]  char_count;
    logic [7:0]  held_ch;
    logic        held_ok;
    logic [8:0]  sign_wait;
    logic        cr_seen;
    int          col;
    logic        skip_line;
    logic [15:0] lines;
    logic [31:0] acc;
    logic        neg_f, sign_f, hex_f, bad_f;
    logic        lex_err;

    function automatic logic digit_ch(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic letter_ch(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic hex_letter(input logic [7:0] c);
        return (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic number_ch(input logic [7:0] c);
        return digit_ch(c) || c == "." || c == "x" || c == "X" || hex_letter(c);
    endfunction

    function automatic logic label_ch(input logic [7:0] c);
        return letter_ch(c) || digit_ch(c) || c == "_";
    endfunction

    function automatic logic symbol_ch(input logic [7:0] c);
        case (c)
            "~", "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "-", "=", "_", "+",
            "{", "}", "[", "]", "|", "\\", ":", ";", "'", "<", ">", "?", ",", ".",
            "/": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic clear_lexer();
        max_len    = 9'd64;
        open_type  = TY_NONE;
        char_count = '0;
        held_ch    = '0;
        held_ok    = 1'b0;
        sign_wait  = '0;
        cr_seen    = 1'b0;
        col        = 0;
        skip_line  = 1'b0;
        lines      = '0;
        acc        = '0;
        {neg_f, sign_f, hex_f, bad_f} = '0;
        lex_err    = 1'b0;
    endtask

    // At most three result items come from one input item.
    task automatic push_token(input logic [7:0] ch, input logic cv, input tok_type_t ty,
                              input logic last, input logic [31:0] val, input logic ok);
        token_res_t r;
        if (step_n < MAX_RES) begin
            r.ch = ch; r.cvalid = cv; r.ttype = ty; r.last = last;
            r.value = val; r.ok = ok; r.line = lines; r.err = lex_err;
            expected_tokens.push_back(r);
            step_n++;
        end
    endtask

    // Numeric value of one emitted number character.
    task automatic add_digit(input logic [7:0] c, input logic [8:0] pos);
        logic [8:0]  dpos;
        logic [31:0] d;
        if (bad_f) return;
        if (pos == 0 && (c == "+" || c == "-")) begin
            sign_f = 1'b1;
            if (c == "-") neg_f = 1'b1;
            return;
        end
        dpos = pos - {8'd0, sign_f};
        if (dpos == 1 && !hex_f && acc == 0 && (c == "x" || c == "X")) begin
            hex_f = 1'b1;
            return;
        end
        if (digit_ch(c)) begin
            d = 32'(c - 8'h30);
        end else if (c >= "A" && c <= "F") begin
            d = 32'(c - 8'h37);
        end else if (c >= "a" && c <= "f") begin
            d = 32'(c - 8'h57);
        end else begin
            bad_f = 1'b1;
            return;
        end
        acc = acc * (hex_f ? 32'd16 : 32'd10) + d;
    endtask

    // The previous character goes out once the next one is known.
    task automatic take_char(input logic [7:0] c);
        if (char_count >= max_len) return;
        if (held_ok) push_token(held_ch, 1'b1, open_type, 1'b0, '0, 1'b0);
        if (open_type == TY_NUM) add_digit(c, char_count);
        held_ch = c;
        held_ok = 1'b1;
        char_count++;
    endtask

    task automatic open_token(input tok_type_t ty);
        open_type  = ty;
        char_count = '0;
        held_ok    = 1'b0;
        held_ch    = '0;
        acc        = '0;
        {neg_f, sign_f, hex_f, bad_f} = '0;
    endtask

    task automatic close_token();
        logic [31:0] val;
        logic        ok;
        val = '0;
        ok  = 1'b0;
        if (open_type == TY_NONE) return;
        if (open_type == TY_NUM && !bad_f) begin
            ok  = 1'b1;
            val = neg_f ? 32'd0 - acc : acc;
        end
        push_token(held_ok ? held_ch : 8'd0, held_ok, open_type, 1'b1, val, ok);
        open_token(TY_NONE);
    endtask

    task automatic single_symbol(input logic [7:0] c);
        open_token(TY_SYM);
        take_char(c);
        close_token();
    endtask

    task automatic flush_tokens();
        logic [7:0] sc;
        sc = sign_wait[7:0];
        if (sign_wait[8]) begin
            sign_wait = '0;
            single_symbol(sc);
        end
        close_token();
    endtask

    task automatic lex_byte(input logic [7:0] b);
        logic [7:0] sc;
        sc = sign_wait[7:0];
        if (b == CH_NUL) begin
            flush_tokens();
            skip_line = 1'b1;
            return;
        end
        // A sign becomes part of a number only when a digit follows.
        if (sign_wait[8]) begin
            sign_wait = '0;
            if (digit_ch(b)) begin
                open_token(TY_NUM);
                take_char(sc);
                take_char(b);
                return;
            end
            single_symbol(sc);
        end
        case (open_type)
            TY_NUM: begin
                if (number_ch(b)) begin
                    take_char(b);
                    return;
                end
                close_token();
            end
            TY_LABEL: begin
                if (label_ch(b)) begin
                    take_char(b);
                    return;
                end
                close_token();
            end
            TY_STR: begin
                if (b == CH_QUOTE) close_token();
                else take_char(b);
                return;
            end
            TY_NONE: ;
            default: close_token();
        endcase
        if (b <= CH_SPACE || b >= 8'h80) return;
        if (digit_ch(b)) begin
            open_token(TY_NUM);
            take_char(b);
        end else if (b == CH_PLUS || b == CH_MINUS) begin
            sign_wait = {1'b1, b};
        end else if (letter_ch(b) || b == "_") begin
            open_token(TY_LABEL);
            take_char(b);
        end else if (b == CH_QUOTE) begin
            open_token(TY_STR);
        end else if (symbol_ch(b)) begin
            single_symbol(b);
        end else begin
            lex_err = 1'b1;
        end
    endtask

    task automatic tokenize_item(input logic [7:0] b, input logic eoi);
        step_n = 0;
        if (eoi) begin
            flush_tokens();
            push_token('0, 1'b0, TY_NONE, 1'b1, '0, 1'b0);
            col = 0;
            skip_line = 1'b0;
            cr_seen = 1'b0;
            return;
        end
        // An LF right after a CR belongs to the same line end.
        if (cr_seen) begin
            cr_seen = 1'b0;
            if (b == CH_LF) return;
        end
        if (col == 0 && lines != 16'hFFFF) lines++;
        if (b == CH_LF || b == CH_CR) begin
            flush_tokens();
            col = 0;
            skip_line = 1'b0;
            cr_seen = (b == CH_CR);
            return;
        end
        col++;
        if (!skip_line) lex_byte(b);
        if (col >= LINE_MAX) begin
            flush_tokens();
            col = 0;
            skip_line = 1'b0;
        end
    endtask

    task automatic report(input string what, input longint exp_v, input longint got_v);
        $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, exp_v, got_v);
        err_count++;
    endtask

    // Compare one result item with the oldest prediction.
    task automatic check_result();
        token_res_t e;
        if (expected_tokens.size() == 0) begin
            report("unexpected item", 0, m_tdata);
            return;
        end
        e = expected_tokens.pop_front();
        if (m_tdata[7:0] != e.ch)      report("tok_char", e.ch, m_tdata[7:0]);
        if (m_tdata[8] != e.cvalid)    report("char_valid", e.cvalid, m_tdata[8]);
        if (m_tuser != e.ttype)        report("tok_type", e.ttype, m_tuser);
        if (m_tlast != e.last)         report("tok_last", e.last, m_tlast);
        if (m_tdata[40:9] != e.value)  report("int_value", e.value, m_tdata[40:9]);
        if (m_tdata[41] != e.ok)       report("int_ok", e.ok, m_tdata[41]);
        if (m_tdata[57:42] != e.line)  report("line_number", e.line, m_tdata[57:42]);
        if (m_tdata[58] != e.err)      report("lex_error", e.err, m_tdata[58]);
        if (m_tdata[63:59] != 5'd0)    report("zero fill", 0, m_tdata[63:59]);
    endtask

    initial begin
        err_count = 0;
        clear_lexer();
    end

    // Watch all three channels at each rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_lexer();
            expected_tokens.delete();
        end else begin
            if (cfg_valid && cfg_ready) max_len = cfg_data;
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready) tokenize_item(s_tdata, s_tlast);
        end
        errors  <= err_count;
        pending <= expected_tokens.size();
    end

endmodule

[tb/config_text_tokenizer_test.sv]
// Top of the tokenizer testbench: clock, reset, byte stimulus, result stalls and verdict.
`timescale 1ns / 100ps

module config_text_tokenizer_test;
    import ctt_pkg::*;

    localparam int LINE_MAX   = 256;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_LEN   = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // in_byte[7:0]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;    // tok_char, char_valid, int_value, int_ok, line_number, lex_error
    logic [2:0]  m_tuser;    // tok_type[2:0]
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;

    int errors;
    int pending;
    int bytes_sent;
    int rx_count;
    int idle_cycles;
    bit no_idling;
    bit hold_done;

    config_text_tokenizer #(.LINE_MAX(LINE_MAX)) uut (.*);

    config_text_tokenizer_checker #(.LINE_MAX(LINE_MAX)) checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog on cycles with no transfer on any channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stall per item, and one long hold-off.
    initial begin
        int gap;
        m_tready  = 1'b0;
        rx_count  = 0;
        hold_done = 1'b0;
        @(posedge aresetn);
        forever begin
            gap = no_idling ? 0 : $urandom_range(0, 18);
            if (rx_count == 30 && !hold_done) begin
                gap = HOLD_LEN;
                hold_done = 1'b1;
            end
            @(negedge aclk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            rx_count++;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eoi = 1'b0);
        int gap;
        gap = no_idling ? 0 : $urandom_range(0, 18);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eoi;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        // Switch between idling and back-to-back stretches.
        if (bytes_sent % 20 == 0) no_idling = ($urandom_range(0, 2) == 0);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
    endtask

    // Drain, let the block settle, then write max_token_len.
    task automatic write_max_len(input logic [8:0] v);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One well-formed token with random content, or some noise.
    task automatic send_random_token();
        string syms;
        string hex_digits;
        string label_chars;
        int    n;
        syms = "~!@#$%^&*()-=_+{}[]|\\:;'<>?,./";
        hex_digits = "0123456789abcdefABCDEF";
        label_chars = "ABCz_09q";
        case ($urandom_range(0, 11))
            0, 1, 2: begin
                n = $urandom_range(0, 2);
                if (n == 1) send_byte("+");
                if (n == 2) send_byte("-");
                if ($urandom_range(0, 1)) begin
                    send_text($urandom_range(0, 1) ? "0x" : "0X");
                    n = $urandom_range(1, 9);
                    repeat (n) send_byte(hex_digits[$urandom_range(0, 21)]);
                end else begin
                    n = $urandom_range(1, 11);
                    repeat (n) send_byte(8'("0" + $urandom_range(0, 9)));
                end
                if ($urandom_range(0, 5) == 0) send_text(".5x");
            end
            3, 4: begin
                send_byte($urandom_range(0, 1) ? 8'("_") : 8'("a" + $urandom_range(0, 25)));
                n = $urandom_range(0, 10);
                repeat (n) send_byte(label_chars[$urandom_range(0, 7)]);
            end
            5: begin
                send_byte(CH_QUOTE);
                n = $urandom_range(0, 12);
                repeat (n) send_byte(8'($urandom_range(8'h23, 8'h7E)));
                if ($urandom_range(0, 3) != 0) send_byte(CH_QUOTE);
            end
            6: send_byte(syms[$urandom_range(0, syms.len() - 1)]);
            7: send_byte($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(8'h80, 8'hFF)));
            8: begin
                n = $urandom_range(0, 2);
                if (n != 1) send_byte(CH_CR);
                if (n != 0) send_byte(CH_LF);
            end
            9, 10: send_byte(8'($urandom_range(0, 255)));
            default: begin
                if ($urandom_range(0, 3) == 0) send_byte(8'h00, 1'b1);
                else send_byte(CH_NUL);
            end
        endcase
        if ($urandom_range(0, 2) != 0) send_byte(CH_SPACE);
    endtask

    task automatic random_phase(input int count);
        int stop;
        stop = bytes_sent + count;
        while (bytes_sent < stop) send_random_token();
    endtask

    initial begin
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        aresetn     = 1'b0;
        bytes_sent  = 0;
        idle_cycles = 0;
        no_idling   = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: signs, hex extremes, labels, empty string, symbols, illegal bytes,
        // NUL skipping, CR, CR LF, end marker.
        write_max_len(9'd64);
        send_text("+12 -0x7FfFffFF _ab9 \"q\"\"\" ~-x");
        send_byte(8'h60);
        send_text("9x 1.5");
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("-");
        send_byte(CH_NUL);
        send_text("j");
        send_byte(CH_CR);
        send_text("a");
        send_byte(8'h00, 1'b1);

        random_phase(20);
        write_max_len(9'd0);
        send_text("\"\" ab 7 ");
        random_phase(15);
        write_max_len(9'd3);
        random_phase(15);

        // Large max_token_len settings.
        write_max_len(9'd256);
        random_phase(15);
        write_max_len(9'd511);
        send_text("-0xFFFFFFFF 4294967296 ");
        write_max_len(9'($urandom_range(1, 300)));
        random_phase(15);
        send_byte(8'h00, 1'b1);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/ctt_pkg.sv
rtl/core/config_text_tokenizer.sv
tb/config_text_tokenizer_checker.sv
tb/config_text_tokenizer_test.sv
